/* rtl/pcd_pkg.sv */
// Shared types, constants and helper functions of the POV clock display controller.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pcd_pkg;

    localparam int PCD_HISTORY_DEPTH = 5;

    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 16;
    localparam int PAT_W    = 16;
    localparam int TIME_W   = 7;
    localparam int TURN_DEG = 360;
    localparam int DVD_W    = COUNT_W + 9;
    localparam int ANGLE_W  = DVD_W + 1;
    localparam int DEG_W    = 11;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RX    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_HALL  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

    localparam logic KIND_LED = 1'b0;
    localparam logic KIND_TX  = 1'b1;

    localparam logic [BYTE_W-1:0] CH_H     = 8'h68;
    localparam logic [BYTE_W-1:0] CH_M     = 8'h6D;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_ACK   = 8'h61;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam logic [COUNT_W-1:0] MIN_PERIOD_RST = 16'd500;
    localparam logic [TIME_W-1:0]  MINUTE_WRAP    = 7'd60;
    localparam logic [TIME_W-1:0]  HOUR_WRAP      = 7'd24;
    localparam logic [ANGLE_W-1:0] HAND_LO        = 26'd179;
    localparam logic [ANGLE_W-1:0] HAND_HI        = 26'd181;
    localparam logic [DEG_W-1:0]   HOUR_DEG       = 11'd15;
    localparam logic [DEG_W-1:0]   MIN_DEG        = 11'd6;
    localparam logic [PAT_W-1:0]   PAT_HOUR       = 16'h00FF;
    localparam logic [PAT_W-1:0]   PAT_MIN        = 16'hFFFF;
    localparam logic [PAT_W-1:0]   PAT_NONE       = 16'h0000;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quo;
    } t_div_res;

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [TIME_W-1:0] parse_two(input logic [BYTE_W-1:0] tens,
                                                    input logic [BYTE_W-1:0] units);
        logic [TIME_W-1:0] u;
        logic [TIME_W-1:0] t;
        u = {3'b000, units[3:0]};
        t = {3'b000, tens[3:0]};
        if (!is_digit(units)) begin
            return '0;
        end
        if (!is_digit(tens)) begin
            return u;
        end
        return u + {t[3:0], 3'b000} + {t[5:0], 1'b0};
    endfunction

    // {hundreds, tens, units}, four bits each; tens by reciprocal 205/2048
    function automatic logic [11:0] to_bcd3(input logic [TIME_W-1:0] v);
        logic              h;
        logic [TIME_W-1:0] r;
        logic [14:0]       p;
        logic [3:0]        t;
        logic [3:0]        u;
        h = (v >= 7'd100);
        r = h ? (v - 7'd100) : v;
        p = {8'b0, r} * 15'd205;
        t = p[14:11];
        u = 4'(r - {t[3:0], 3'b000} - {2'b00, t, 1'b0});
        return {3'b000, h, t, u};
    endfunction

endpackage

`default_nettype wire

/* rtl/pcd_if.sv */
// Channel interfaces: input item, result item and configuration write.
// Depends on pcd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pcd_in_if
    import pcd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [BYTE_W-1:0]  rx_byte;
    logic [COUNT_W-1:0] timer_count;

    modport source (output valid, cmd, rx_byte, timer_count, input ready);
    modport sink   (input valid, cmd, rx_byte, timer_count, output ready);
endinterface

interface pcd_out_if
    import pcd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [PAT_W-1:0]  led_pattern;
    logic [BYTE_W-1:0] tx_byte;
    logic              last;

    modport source (output valid, kind, led_pattern, tx_byte, last, input ready);
    modport sink   (input valid, kind, led_pattern, tx_byte, last, output ready);
endinterface

interface pcd_cfg_if
    import pcd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/pcd_div.sv */
// Restoring divider, one quotient bit per cycle, for the angle computation.
// Depends on pcd_pkg for widths and the result struct.
`timescale 1ns / 1ps
`default_nettype none

module pcd_div
    import pcd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DVD_W-1:0]   i_dividend,
    input  logic [COUNT_W-1:0] i_divisor,
    output t_div_res           o_res
);

    localparam int CNT_W = $clog2(DVD_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [COUNT_W-1:0]   r_rem;
    logic [COUNT_W-1:0]   r_dvs;
    logic [DVD_W-1:0]     r_quo;

    logic [COUNT_W:0]     shifted;
    logic [COUNT_W+1:0]   diff;
    logic                 fits;
    logic [COUNT_W-1:0]   n_rem;

    always_comb begin
        shifted = {r_rem, r_quo[DVD_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        fits    = !diff[COUNT_W+1];
        n_rem   = fits ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;

endmodule

`default_nettype wire

/* rtl/pov_clock_display_controller.sv */
// POV clock display controller: clock keeping, serial time text, LED angle query.
// Minute tick and hall pulse: no result. Serial byte: accepted, then one result per cycle
// while the output is ready (up to 6). Angle query: the 25-step divider runs, then the LED
// result is registered; a zero period skips the divider. Ready only when idle.
// Synchronous active-low reset clears clock, period, history and min_period to 500.
`timescale 1ns / 1ps
`default_nettype none

module pov_clock_display_controller
    import pcd_pkg::*;
#(
    parameter int HISTORY_DEPTH = PCD_HISTORY_DEPTH
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcd_cfg_if.sink    i_cfg,
    pcd_in_if.sink     i_in,
    pcd_out_if.source  o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_LED  = 2'd2;
    localparam logic [1:0] S_TX   = 2'd3;

    localparam int MB_H_HUND = 0;
    localparam int MB_H_TENS = 1;
    localparam int MB_H_UNIT = 2;
    localparam int MB_COLON  = 3;
    localparam int MB_M_HUND = 4;
    localparam int MB_M_TENS = 5;
    localparam int MB_M_UNIT = 6;
    localparam int MB_ACK    = 7;

    logic [1:0]          r_state,      n_state;
    logic [COUNT_W-1:0]  r_min_period, n_min_period;
    logic [TIME_W-1:0]   r_hours,      n_hours;
    logic [TIME_W-1:0]   r_minutes,    n_minutes;
    logic [COUNT_W-1:0]  r_period,     n_period;
    logic [BYTE_W-1:0]   r_hist [HISTORY_DEPTH];
    logic [BYTE_W-1:0]   n_hist [HISTORY_DEPTH];
    logic [7:0]          r_mask,       n_mask;
    logic [11:0]         r_hdig,       n_hdig;
    logic [11:0]         r_mdig,       n_mdig;
    logic                r_zero,       n_zero;
    logic                r_out_valid,  n_out_valid;
    logic                r_out_kind,   n_out_kind;
    logic [PAT_W-1:0]    r_out_pat,    n_out_pat;
    logic [BYTE_W-1:0]   r_out_tx,     n_out_tx;
    logic                r_out_last,   n_out_last;

    logic                out_free;
    logic                div_start;
    t_div_res            div_res;
    logic [TIME_W-1:0]   tick_min;
    logic [TIME_W-1:0]   tick_hour;
    logic [7:0]          ser_mask;
    logic                ack;
    logic [2:0]          idx;
    logic [BYTE_W-1:0]   tx_char;
    logic [ANGLE_W-1:0]  ang_lo;
    logic [ANGLE_W-1:0]  ang_hi;
    logic [ANGLE_W-1:0]  h_deg;
    logic [ANGLE_W-1:0]  m_deg;
    logic [PAT_W-1:0]    led_pat;

    pcd_div u_pcd_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({9'b0, i_in.timer_count} * DVD_W'(TURN_DEG)),
        .i_divisor  (r_period),
        .o_res      (div_res)
    );

    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        tick_min  = r_minutes + 1'b1;
        tick_hour = r_hours;
        if (tick_min >= MINUTE_WRAP) begin
            tick_min  = '0;
            tick_hour = r_hours + 1'b1;
        end
        if (tick_hour >= HOUR_WRAP) begin
            tick_hour = '0;
        end
    end

    always_comb begin
        ack      = (i_in.rx_byte != CH_M) && (r_hist[1] == CH_COLON);
        ser_mask = '0;
        if (i_in.rx_byte == CH_H) begin
            ser_mask[MB_H_HUND] = (r_hours >= 7'd100);
            ser_mask[MB_H_TENS] = (r_hours >= 7'd10);
            ser_mask[MB_H_UNIT] = 1'b1;
            ser_mask[MB_COLON]  = 1'b1;
            ser_mask[MB_M_HUND] = (r_minutes >= 7'd100);
            ser_mask[MB_M_TENS] = (r_minutes >= 7'd10);
            ser_mask[MB_M_UNIT] = 1'b1;
        end
        ser_mask[MB_ACK] = ack;
    end

    always_comb begin
        idx = '0;
        for (int i = 7; i >= 0; i--) begin
            if (r_mask[i]) begin
                idx = 3'(i);
            end
        end
        unique case (idx)
            3'd0:    tx_char = CH_ZERO | {4'h0, r_hdig[11:8]};
            3'd1:    tx_char = CH_ZERO | {4'h0, r_hdig[7:4]};
            3'd2:    tx_char = CH_ZERO | {4'h0, r_hdig[3:0]};
            3'd3:    tx_char = CH_COLON;
            3'd4:    tx_char = CH_ZERO | {4'h0, r_mdig[11:8]};
            3'd5:    tx_char = CH_ZERO | {4'h0, r_mdig[7:4]};
            3'd6:    tx_char = CH_ZERO | {4'h0, r_mdig[3:0]};
            3'd7:    tx_char = CH_ACK;
        endcase
    end

    always_comb begin
        ang_lo = {1'b0, div_res.quo} + HAND_LO;
        ang_hi = {1'b0, div_res.quo} + HAND_HI;
        h_deg  = ANGLE_W'({4'b0, r_hours} * HOUR_DEG);
        m_deg  = ANGLE_W'({4'b0, r_minutes} * MIN_DEG);
        priority if (r_zero) begin
            led_pat = PAT_NONE;
        end else if (h_deg >= ang_lo && h_deg <= ang_hi) begin
            led_pat = PAT_HOUR;
        end else if (m_deg >= ang_lo && m_deg <= ang_hi) begin
            led_pat = PAT_MIN;
        end else begin
            led_pat = PAT_NONE;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_min_period = r_min_period;
        n_hours      = r_hours;
        n_minutes    = r_minutes;
        n_period     = r_period;
        n_hist       = r_hist;
        n_mask       = r_mask;
        n_hdig       = r_hdig;
        n_mdig       = r_mdig;
        n_zero       = r_zero;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_kind   = r_out_kind;
        n_out_pat    = r_out_pat;
        n_out_tx     = r_out_tx;
        n_out_last   = r_out_last;
        div_start    = 1'b0;

        if (i_cfg.valid) begin
            n_min_period = i_cfg.data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    unique case (i_in.cmd)
                        CMD_TICK: begin
                            n_minutes = tick_min;
                            n_hours   = tick_hour;
                        end
                        CMD_HALL: begin
                            if (i_in.timer_count > r_min_period) begin
                                n_period = i_in.timer_count;
                            end
                        end
                        CMD_QUERY: begin
                            n_zero    = (r_period == '0);
                            div_start = (r_period != '0);
                            n_state   = (r_period == '0) ? S_LED : S_DIV;
                        end
                        CMD_RX: begin
                            n_hist[0] = i_in.rx_byte;
                            for (int i = 1; i < HISTORY_DEPTH; i++) begin
                                n_hist[i] = r_hist[i-1];
                            end
                            n_mask = ser_mask;
                            n_hdig = to_bcd3(r_hours);
                            n_mdig = to_bcd3(r_minutes);
                            if (ack) begin
                                n_hours   = parse_two(r_hist[3], r_hist[2]);
                                n_minutes = parse_two(r_hist[0], i_in.rx_byte);
                            end
                            if (ser_mask != '0) begin
                                n_state = S_TX;
                            end
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    n_state = S_LED;
                end
            end
            S_LED: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_LED;
                    n_out_pat   = led_pat;
                    n_out_tx    = '0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_TX: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_TX;
                    n_out_pat   = PAT_NONE;
                    n_out_tx    = tx_char;
                    n_out_last  = ((r_mask & (r_mask - 1'b1)) == '0);
                    n_mask      = r_mask & (r_mask - 1'b1);
                    if ((r_mask & (r_mask - 1'b1)) == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_min_period <= MIN_PERIOD_RST;
            r_hours      <= '0;
            r_minutes    <= '0;
            r_period     <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_min_period <= n_min_period;
            r_hours      <= n_hours;
            r_minutes    <= n_minutes;
            r_period     <= n_period;
            r_out_valid  <= n_out_valid;
            r_hist       <= n_hist;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask     <= n_mask;
        r_hdig     <= n_hdig;
        r_mdig     <= n_mdig;
        r_zero     <= n_zero;
        r_out_kind <= n_out_kind;
        r_out_pat  <= n_out_pat;
        r_out_tx   <= n_out_tx;
        r_out_last <= n_out_last;
    end

    assign i_cfg.ready       = 1'b1;
    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out_kind;
    assign o_out.led_pattern = r_out_pat;
    assign o_out.tx_byte     = r_out_tx;
    assign o_out.last        = r_out_last;

endmodule

`default_nettype wire

/* rtl/pcd_chk.sv */
// Port-level checker for the POV clock display controller, bound to the top level.
// Depends on pcd_pkg for command and result kind codes.
`timescale 1ns / 1ps
`default_nettype none

module pcd_chk
    import pcd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [CMD_W-1:0]  i_in_cmd,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_out_kind,
    input logic [PAT_W-1:0]  i_out_pattern,
    input logic [BYTE_W-1:0] i_out_tx,
    input logic              i_out_last
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("block not idle after reset");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_cmd == CMD_QUERY |=> !i_in_ready)
        else $error("input accepted during angle query");

    a_led_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_LED |-> i_out_last && i_out_tx == '0)
        else $error("LED beat malformed");

    a_tx_no_pat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_TX |-> i_out_pattern == PAT_NONE)
        else $error("serial beat carries LED pattern");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_tx)
            && $stable(i_out_pattern) && $stable(i_out_last) && $stable(i_out_kind))
        else $error("stalled result beat changed");

endmodule

bind pov_clock_display_controller pcd_chk u_pcd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_cmd      (i_in.cmd),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_kind    (o_out.kind),
    .i_out_pattern (o_out.led_pattern),
    .i_out_tx      (o_out.tx_byte),
    .i_out_last    (o_out.last)
);

`default_nettype wire

/* test/pcd_checker.sv */
// Result checker for the POV clock display controller: watches the configuration, item
// and result channels, predicts each result beat and compares it field by field.
// Depends on pcd_pkg and the channel interfaces of pcd_if.
`timescale 1ns / 1ps

module pcd_checker
    import pcd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    pcd_cfg_if   i_cfg,
    pcd_in_if    i_in,
    pcd_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic              kind;
        logic [PAT_W-1:0]  led_pattern;
        logic [BYTE_W-1:0] tx_byte;
        logic              last;
    } beat_t;

    beat_t              expected_beats[$];
    beat_t              item_beats[$];
    logic [COUNT_W-1:0] min_period;
    logic [COUNT_W-1:0] period;
    logic [TIME_W-1:0]  hours;
    logic [TIME_W-1:0]  minutes;
    logic [BYTE_W-1:0]  history[PCD_HISTORY_DEPTH];
    int                 fails = 0;
    int                 pending = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;

    function automatic logic [TIME_W-1:0] digit_pair(input logic [BYTE_W-1:0] tens,
                                                      input logic [BYTE_W-1:0] units);
        int t;
        int u;
        t = int'(tens) - int'(CH_ZERO);
        u = int'(units) - int'(CH_ZERO);
        if (u < 0 || u > 9) begin
            return '0;
        end
        if (t < 0 || t > 9) begin
            return TIME_W'(u);
        end
        return TIME_W'(10 * t + u);
    endfunction

    function automatic beat_t tx_beat(input logic [BYTE_W-1:0] ch);
        beat_t b;
        b         = '0;
        b.kind    = KIND_TX;
        b.tx_byte = ch;
        return b;
    endfunction

    task automatic push_number(input logic [TIME_W-1:0] v);
        if (v >= 7'd100) begin
            item_beats.push_back(tx_beat(CH_ZERO + BYTE_W'(v / 100)));
        end
        if (v >= 7'd10) begin
            item_beats.push_back(tx_beat(CH_ZERO + BYTE_W'((v / 10) % 10)));
        end
        item_beats.push_back(tx_beat(CH_ZERO + BYTE_W'(v % 10)));
    endtask

    task automatic predict_item(input logic [CMD_W-1:0]   cmd,
                                input logic [BYTE_W-1:0]  rx,
                                input logic [COUNT_W-1:0] count);
        beat_t b;
        int    angle;
        int    hour_deg;
        int    min_deg;
        item_beats.delete();
        case (cmd)
            CMD_TICK: begin
                minutes = minutes + 1'b1;
                if (minutes >= MINUTE_WRAP) begin
                    minutes = '0;
                    hours   = hours + 1'b1;
                end
                if (hours >= HOUR_WRAP) begin
                    hours = '0;
                end
            end
            CMD_HALL: begin
                if (count > min_period) begin
                    period = count;
                end
            end
            CMD_QUERY: begin
                b             = '0;
                b.kind        = KIND_LED;
                b.led_pattern = PAT_NONE;
                if (period != '0) begin
                    angle    = (TURN_DEG * int'(count)) / int'(period);
                    hour_deg = int'(hours) * int'(HOUR_DEG);
                    min_deg  = int'(minutes) * int'(MIN_DEG);
                    if (hour_deg >= angle + int'(HAND_LO) && hour_deg <= angle + int'(HAND_HI)) begin
                        b.led_pattern = PAT_HOUR;
                    end else if (min_deg >= angle + int'(HAND_LO) &&
                                 min_deg <= angle + int'(HAND_HI)) begin
                        b.led_pattern = PAT_MIN;
                    end
                end
                item_beats.push_back(b);
            end
            default: begin
                if (rx == CH_H) begin
                    push_number(hours);
                    item_beats.push_back(tx_beat(CH_COLON));
                    push_number(minutes);
                end
                for (int i = PCD_HISTORY_DEPTH - 1; i > 0; i--) begin
                    history[i] = history[i-1];
                end
                history[0] = rx;
                if (rx != CH_M && history[2] == CH_COLON) begin
                    item_beats.push_back(tx_beat(CH_ACK));
                    hours   = digit_pair(history[4], history[3]);
                    minutes = digit_pair(history[1], history[0]);
                end
            end
        endcase
        foreach (item_beats[i]) begin
            b      = item_beats[i];
            b.last = (i == item_beats.size() - 1);
            expected_beats.push_back(b);
        end
    endtask

    always @(posedge i_clk) begin
        beat_t got;
        beat_t want;
        if (!i_rst_n) begin
            min_period = MIN_PERIOD_RST;
            period     = '0;
            hours      = '0;
            minutes    = '0;
            for (int i = 0; i < PCD_HISTORY_DEPTH; i++) begin
                history[i] = '0;
            end
            expected_beats.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = {i_out.kind, i_out.led_pattern, i_out.tx_byte, i_out.last};
                if (expected_beats.size() == 0) begin
                    $display("%0t: result beat with none expected: kind=%0b pattern=%h tx=%h last=%0b",
                             $time, got.kind, got.led_pattern, got.tx_byte, got.last);
                    fails++;
                end else begin
                    want = expected_beats.pop_front();
                    if (got.kind !== want.kind || got.led_pattern !== want.led_pattern ||
                        got.tx_byte !== want.tx_byte || got.last !== want.last) begin
                        $display("%0t: result mismatch: expected kind=%0b pattern=%h tx=%h last=%0b",
                                 $time, want.kind, want.led_pattern, want.tx_byte, want.last);
                        $display("%0t:                  actual   kind=%0b pattern=%h tx=%h last=%0b",
                                 $time, got.kind, got.led_pattern, got.tx_byte, got.last);
                        fails++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                min_period = i_cfg.data;
            end
            if (i_in.valid && i_in.ready) begin
                predict_item(i_in.cmd, i_in.rx_byte, i_in.timer_count);
            end
        end
        pending = expected_beats.size();
    end

endmodule

/* test/tb.sv */
// Testbench top for the POV clock display controller: clock, reset, directed and random
// items, configuration writes and the verdict. Depends on pcd_pkg, pcd_if, the block
// and pcd_checker, which predicts and compares the result beats.
`timescale 1ns / 1ps

module tb;
    import pcd_pkg::*;

    localparam int TAIL_CYCLES = 40;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   items_sent = 0;
    bit   item_up = 1'b0;
    bit   send_gaps = 1'b0;
    bit   recv_gaps = 1'b0;

    pcd_cfg_if cfg_ch ();
    pcd_in_if  item_ch ();
    pcd_out_if beat_ch ();

    pov_clock_display_controller DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (item_ch),
        .o_out   (beat_ch)
    );

    pcd_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_ch),
        .i_in         (item_ch),
        .i_out        (beat_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

    initial begin
        beat_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (recv_gaps && $urandom_range(0, 3) == 0) begin
                beat_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            beat_ch.ready <= 1'b1;
        end
    end

    task automatic hold_items();
        if (item_up) begin
            item_ch.valid <= 1'b0;
            item_up = 1'b0;
        end
    endtask

    task automatic send_item(input logic [CMD_W-1:0]   cmd,
                             input logic [BYTE_W-1:0]  rx,
                             input logic [COUNT_W-1:0] count);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            hold_items();
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.cmd         <= cmd;
        item_ch.rx_byte     <= rx;
        item_ch.timer_count <= count;
        item_up = 1'b1;
        do @(posedge i_clk); while (!item_ch.ready);
        items_sent++;
    endtask

    task automatic drain_results();
        hold_items();
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_min_period(input logic [COUNT_W-1:0] value);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(CMD_RX, BYTE_W'(s[i]), COUNT_W'($urandom));
        end
    endtask

    task automatic send_time(input int hh, input int mm, input bit spoil);
        logic [BYTE_W-1:0] txt[5];
        int                first;
        first  = 0;
        txt[0] = CH_ZERO + BYTE_W'(hh / 10);
        txt[1] = CH_ZERO + BYTE_W'(hh % 10);
        txt[2] = CH_COLON;
        txt[3] = CH_ZERO + BYTE_W'(mm / 10);
        txt[4] = CH_ZERO + BYTE_W'(mm % 10);
        if (spoil) begin
            case ($urandom_range(0, 3))
                0: txt[$urandom_range(0, 4)] = BYTE_W'($urandom);
                1: txt[4] = CH_M;
                2: first = 1;
                default: txt[$urandom_range(0, 1) * 3] = BYTE_W'($urandom_range(8'h3B, 8'h7F));
            endcase
        end
        for (int i = first; i < 5; i++) begin
            send_item(CMD_RX, txt[i], COUNT_W'($urandom));
        end
    endtask

    // aim at a hand when the period is 360, straddling the edges of the match window
    task automatic send_query(input int hand_deg);
        int c;
        c = hand_deg - 184 + $urandom_range(0, 6);
        if (c < 0) begin
            c = $urandom_range(0, 3);
        end
        send_item(CMD_QUERY, BYTE_W'($urandom), COUNT_W'(c));
    endtask

    task automatic run_scene(input logic [COUNT_W-1:0] floor_count);
        int hh;
        int mm;
        int c;
        hh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
        mm = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
        if ($urandom_range(0, 9) < 7) begin
            send_time(hh, mm, $urandom_range(0, 4) == 0);
        end
        case ($urandom_range(0, 3))
            0, 1: send_item(CMD_HALL, BYTE_W'($urandom), COUNT_W'(360));
            2: begin
                c = int'(floor_count) + $urandom_range(0, 2) - 1;
                if (c < 0) begin
                    c = 0;
                end
                if (c > 65535) begin
                    c = 65535;
                end
                send_item(CMD_HALL, BYTE_W'($urandom), COUNT_W'(c));
            end
            default: send_item(CMD_HALL, BYTE_W'($urandom), COUNT_W'($urandom));
        endcase
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 2) == 0) begin
                send_item(CMD_QUERY, BYTE_W'($urandom), COUNT_W'($urandom));
            end else begin
                send_query($urandom_range(0, 1) ? hh * 15 : mm * 6);
            end
        end
        repeat ($urandom_range(0, 3)) begin
            send_item(CMD_TICK, BYTE_W'($urandom), COUNT_W'($urandom));
        end
        if ($urandom_range(0, 1) == 0) begin
            send_item(CMD_RX, CH_H, COUNT_W'($urandom));
        end
        if ($urandom_range(0, 3) == 0) begin
            send_item(CMD_W'($urandom), BYTE_W'($urandom), COUNT_W'($urandom));
        end
        if ($urandom_range(0, 3) == 0) begin
            drain_results();
        end
    endtask

    initial begin
        logic [COUNT_W-1:0] floors[4];
        int                 goal;
        i_rst_n             <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.cmd         <= CMD_TICK;
        item_ch.rx_byte     <= '0;
        item_ch.timer_count <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.data         <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        send_item(CMD_QUERY, 8'h00, 16'h0000);
        send_item(CMD_HALL, 8'hFF, MIN_PERIOD_RST);
        send_item(CMD_HALL, 8'h00, MIN_PERIOD_RST + 1'b1);
        send_item(CMD_RX, CH_H, 16'hFFFF);
        send_text("06:30");
        send_item(CMD_QUERY, 8'hFF, 16'h0000);
        send_item(CMD_QUERY, 8'h00, 16'hFFFF);
        send_text("99:99");
        send_item(CMD_RX, CH_H, 16'h0000);
        send_item(CMD_TICK, 8'hFF, 16'hFFFF);
        send_text("x5:9y");
        send_text("2:4m");
        send_item(CMD_RX, CH_H, 16'hFFFF);

        floors = '{16'd0, 16'hFFFF, COUNT_W'($urandom_range(1, 359)), MIN_PERIOD_RST};
        foreach (floors[p]) begin
            write_min_period(floors[p]);
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_gaps = ($urandom_range(0, 3) != 0);
            goal = items_sent + 58;
            while (items_sent < goal) begin
                run_scene(floors[p]);
            end
        end

        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        goal = items_sent + 30;
        while (items_sent < goal) begin
            run_scene(MIN_PERIOD_RST);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
